// ===== hdl/itd_pkg.sv =====
`default_nettype none

package itd_pkg;

  localparam int VALUE_WIDTH = 32;
  // decimal digits needed for the magnitude of a VALUE_WIDTH-bit value (log10(2) ~ 0.30103)
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);

  localparam logic [6:0] CHAR_ZERO  = 7'd48;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_CONV,
    CELL_SHIFT
  } cell_mode_t;

  typedef struct packed {
    cell_mode_t mode;
    logic       bit_in;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/itd_digit_cell.sv =====
`default_nettype none

module itd_digit_cell (
  input  logic              clk,
  input  itd_pkg::cell_ctrl_t ctrl,
  input  logic              bit_in,
  input  logic [3:0]        digit_in,
  output logic              bit_out,
  output logic [3:0]        digit_out
);
  import itd_pkg::*;

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  // add-3 correction so the left shift carries into the next decade
  assign adj       = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  assign bit_out   = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    unique case (ctrl.mode)
      CELL_HOLD:  digit_nxt = digit_r;
      CELL_CLEAR: digit_nxt = 4'd0;
      CELL_CONV:  digit_nxt = {adj[2:0], bit_in};
      CELL_SHIFT: digit_nxt = digit_in;
      default:    digit_nxt = digit_r;
    endcase
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/itd_digit_chain.sv =====
`default_nettype none

module itd_digit_chain (
  input  logic                clk,
  input  itd_pkg::cell_ctrl_t ctrl,
  output logic [3:0]          top_digit
);
  import itd_pkg::*;

  logic [3:0] digit [NUM_DIGITS];
  logic       carry [NUM_DIGITS-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic       cell_bit_in;
    logic [3:0] cell_digit_in;

    if (i == 0) begin : g_low
      assign cell_bit_in   = ctrl.bit_in;
      assign cell_digit_in = 4'd0;
    end else begin : g_mid
      assign cell_bit_in   = carry[i-1];
      assign cell_digit_in = digit[i-1];
    end

    if (i == NUM_DIGITS - 1) begin : g_top
      // the top decade never overflows for a VALUE_WIDTH-bit magnitude
      itd_digit_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (cell_bit_in),
        .digit_in  (cell_digit_in),
        .bit_out   (),
        .digit_out (digit[i])
      );
    end else begin : g_inner
      itd_digit_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .bit_in    (cell_bit_in),
        .digit_in  (cell_digit_in),
        .bit_out   (carry[i]),
        .digit_out (digit[i])
      );
    end
  end

  assign top_digit = digit[NUM_DIGITS-1];

endmodule

`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii_unit.sv =====
// channel  ports                               direction  meaning
// in       in_valid, in_ready, in_value        in         signed integer, one per item
// out      out_valid, out_ready, out_char_code,
//          out_last                            out        one ASCII character per item
//
// An accepted value is shifted MSB first through a row of BCD digit cells,
// one bit a cycle. Leading zero digits are then shifted out, one per cycle,
// a further step hands over to emit, and the characters follow at one per
// cycle when out is not stalled, a minus sign first for a negative value.
// in_ready is high only in idle; a new value is taken once the last character
// sits in the output register. Synchronous active-low reset clears control.
`default_nettype none

module signed_int_to_decimal_ascii_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [itd_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [6:0]                          out_char_code,
  output logic                                out_last
);
  import itd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                   state_r;
  logic [VALUE_WIDTH-1:0]   mag_r;
  logic [BIT_CNT_W-1:0]     bit_cnt_r;
  logic [DIGIT_CNT_W-1:0]   left_r;
  logic                     minus_r;
  logic                     out_valid_r;
  logic [6:0]               out_char_r;
  logic                     out_last_r;

  logic [VALUE_WIDTH-1:0]   v;
  logic [VALUE_WIDTH-1:0]   mag;
  logic                     in_fire;
  logic                     slot_free;
  logic                     skip_zero;
  logic                     last_digit;
  logic [3:0]               top_digit;
  cell_ctrl_t               ctrl;

  assign v         = in_value;
  assign mag       = v[VALUE_WIDTH-1] ? (~v + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : v;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign last_digit = (left_r == DIGIT_CNT_W'(1));
  assign skip_zero = (top_digit == 4'd0) && !last_digit;

  always_comb begin
    ctrl.bit_in = mag_r[VALUE_WIDTH-1];
    ctrl.mode   = CELL_HOLD;
    unique case (state_r)
      ST_IDLE: if (in_fire) ctrl.mode = CELL_CLEAR;
      ST_CONV: ctrl.mode = CELL_CONV;
      ST_SKIP: if (skip_zero) ctrl.mode = CELL_SHIFT;
      ST_EMIT: if (slot_free && !minus_r) ctrl.mode = CELL_SHIFT;
      default: ctrl.mode = CELL_HOLD;
    endcase
  end

  itd_digit_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .top_digit (top_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      minus_r     <= 1'b0;
    end else begin
      // in emit the output register is refilled whenever it frees up
      if (out_valid_r && out_ready && (state_r != ST_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            mag_r     <= mag;
            minus_r   <= v[VALUE_WIDTH-1];
            bit_cnt_r <= BIT_CNT_W'(VALUE_WIDTH - 1);
            state_r   <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_r <= mag_r << 1;
          if (bit_cnt_r == '0) begin
            left_r  <= DIGIT_CNT_W'(NUM_DIGITS);
            state_r <= ST_SKIP;
          end else begin
            bit_cnt_r <= bit_cnt_r - 1'b1;
          end
        end
        ST_SKIP: begin
          if (skip_zero) begin
            left_r <= left_r - 1'b1;
          end else begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            if (minus_r) begin
              out_char_r <= CHAR_MINUS;
              out_last_r <= 1'b0;
              minus_r    <= 1'b0;
            end else begin
              out_char_r <= CHAR_ZERO + {3'b000, top_digit};
              out_last_r <= last_digit;
              left_r     <= left_r - 1'b1;
              if (last_digit) begin
                state_r <= ST_IDLE;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/itd_checker.sv =====
`default_nettype none

module itd_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [itd_pkg::VALUE_WIDTH-1:0] in_value,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic [6:0]                          out_char_code,
  input  logic                                out_last
);
  import itd_pkg::*;

  // a stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char_code) && $stable(out_last))
    else $error("output item changed while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS) ||
                  ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + 7'd9)))
    else $error("character outside minus and digits");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == CHAR_MINUS) |-> !out_last)
    else $error("minus sign flagged as last");

  // conversion keeps the input closed for a while after an item
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after an item");

endmodule

bind signed_int_to_decimal_ascii_unit itd_checker u_itd_checker (.*);

`default_nettype wire
